// ===== rtl/fpo_pkg.sv =====
// fpo_pkg: stage payload types and constants for fp16_one_plus_gamma
// no dependencies
`default_nettype none
package fpo_pkg;

	localparam int unsigned MAG_W = 41;
	localparam logic [MAG_W-1:0] ONE_FIX = MAG_W'(1) << 24;
	localparam logic [14:0] HALF_INF = 15'h7C00;
	localparam logic [14:0] HALF_QNAN = 15'h7E00;
	localparam logic [4:0] EXP_MAX = 5'h1F;

	typedef struct packed {
		logic special;
		logic [15:0] word;
		logic sign;
		logic [MAG_W-1:0] mag;
	} add_t;

	typedef struct packed {
		logic special;
		logic [15:0] word;
		logic sign;
		logic [MAG_W-1:0] mag;
		logic [5:0] pos;
		logic zero;
	} lzc_t;

	typedef struct packed {
		logic special;
		logic [15:0] word;
		logic sign;
		logic [23:0] sig;
		logic [5:0] exp;
	} rnd_t;

endpackage
`default_nettype wire

// ===== rtl/fpo_if.sv =====
// fpo_if: valid/ready channel interfaces for half words
// no dependencies
`default_nettype none
interface fpo_in_if;
	logic valid;
	logic ready;
	logic [15:0] half_in;
	modport source(output valid, output half_in, input ready);
	modport sink(input valid, input half_in, output ready);
endinterface

interface fpo_out_if;
	logic valid;
	logic ready;
	logic [15:0] half_out;
	modport source(output valid, output half_out, input ready);
	modport sink(input valid, input half_out, output ready);
endinterface
`default_nettype wire

// ===== rtl/fpo_add.sv =====
// fpo_add: decodes a half word and adds one in fixed point
// depends on fpo_pkg
`default_nettype none
module fpo_add (
	input wire logic [15:0] half,
	input wire logic enable,
	output fpo_pkg::add_t res
);
	logic [4:0] ex;
	logic [9:0] man;
	logic sgn, nan, inf;
	logic [4:0] sh;
	logic [fpo_pkg::MAG_W-1:0] mx;

	always_comb begin
		ex = half[14:10];
		man = half[9:0];
		sgn = half[15];
		nan = (ex == fpo_pkg::EXP_MAX) && (man != 10'd0);
		inf = (ex == fpo_pkg::EXP_MAX) && (man == 10'd0);
		sh = (ex == 5'd0) ? 5'd0 : ex - 5'd1;
		mx = fpo_pkg::MAG_W'({ex != 5'd0, man}) << sh;
		res.special = !enable || nan || inf;
		if (!enable) begin
			res.word = half;
		end else if (nan) begin
			res.word = {sgn, fpo_pkg::HALF_QNAN};
		end else begin
			res.word = {sgn, fpo_pkg::HALF_INF};
		end
		if (!sgn) begin
			res.mag = mx + fpo_pkg::ONE_FIX;
			res.sign = 1'b0;
		end else if (mx > fpo_pkg::ONE_FIX) begin
			res.mag = mx - fpo_pkg::ONE_FIX;
			res.sign = 1'b1;
		end else begin
			res.mag = fpo_pkg::ONE_FIX - mx;
			res.sign = 1'b0;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/fpo_lzc.sv =====
// fpo_lzc: leading one position of the fixed point sum
// depends on fpo_pkg
`default_nettype none
module fpo_lzc (
	input wire fpo_pkg::add_t a,
	output fpo_pkg::lzc_t res
);
	always_comb begin
		res.special = a.special;
		res.word = a.word;
		res.sign = a.sign;
		res.mag = a.mag;
		res.zero = (a.mag == '0);
		res.pos = 6'd0;
		for (int i = 0; i < fpo_pkg::MAG_W; i++) begin
			if (a.mag[i]) begin
				res.pos = 6'(i);
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/fpo_round32.sv =====
// fpo_round32: normalizes the sum and rounds it to single precision
// depends on fpo_pkg
`default_nettype none
module fpo_round32 (
	input wire fpo_pkg::lzc_t a,
	output fpo_pkg::rnd_t res
);
	logic [fpo_pkg::MAG_W-1:0] norm;
	logic [23:0] keep;
	logic up;
	logic [24:0] sum;

	always_comb begin
		norm = a.mag << (6'd40 - a.pos);
		keep = norm[40:17];
		up = norm[16] && ((norm[15:0] != 16'd0) || keep[0]);
		sum = {1'b0, keep} + 25'(up);
		res.sign = a.sign;
		res.special = a.special || a.zero;
		res.word = a.special ? a.word : 16'h0000;
		if (sum[24]) begin
			res.sig = 24'h800000;
			res.exp = a.pos - 6'd8;
		end else begin
			res.sig = sum[23:0];
			res.exp = a.pos - 6'd9;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/fpo_pack.sv =====
// fpo_pack: rounds to half precision and packs the result word
// depends on fpo_pkg
`default_nettype none
module fpo_pack (
	input wire fpo_pkg::rnd_t a,
	output logic [15:0] half
);
	logic up;
	logic [11:0] sum;
	logic [6:0] ex;
	logic [9:0] man;

	always_comb begin
		up = a.sig[12] && ((a.sig[11:0] != 12'd0) || a.sig[13]);
		sum = {1'b0, a.sig[23:13]} + 12'(up);
		ex = {1'b0, a.exp} + 7'(sum[11]);
		man = sum[11] ? 10'd0 : sum[9:0];
		if (a.special) begin
			half = a.word;
		end else if (ex >= 7'(fpo_pkg::EXP_MAX)) begin
			half = {a.sign, fpo_pkg::HALF_INF};
		end else begin
			half = {a.sign, ex[4:0], man};
		end
	end
endmodule
`default_nettype wire

// ===== rtl/fp16_one_plus_gamma.sv =====
// fp16_one_plus_gamma: half(1 + x) through single precision, or pass-through
// depends on fpo_pkg, fpo_if, fpo_add, fpo_lzc, fpo_round32, fpo_pack
// pipeline registers: half_s1, p_s2, p_s3, p_s4 and half_s5, in order from input accept to result valid
// throughput: one item per cycle; pipeline stalls as a whole on output backpressure
// reset: arst_n clears stage valids and enable (pass-through)
`default_nettype none
module fp16_one_plus_gamma (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic cfg_wdata,
	fpo_in_if.sink in_ch,
	fpo_out_if.source out_ch
);
	logic enable_q;
	logic adv;
	logic v1_s1, v2_s2, v3_s3, v4_s4, v5_s5;
	logic [15:0] half_s1, half_s5;
	logic en_s1;
	fpo_pkg::add_t add_c, p_s2;
	fpo_pkg::lzc_t lzc_c, p_s3;
	fpo_pkg::rnd_t rnd_c, p_s4;
	logic [15:0] pack_c;

	assign adv = !v5_s5 || out_ch.ready;
	assign in_ch.ready = adv;
	assign out_ch.valid = v5_s5;
	assign out_ch.half_out = half_s5;

	fpo_add u_add (.half(half_s1), .enable(en_s1), .res(add_c));
	fpo_lzc u_lzc (.a(p_s2), .res(lzc_c));
	fpo_round32 u_rnd (.a(p_s3), .res(rnd_c));
	fpo_pack u_pack (.a(p_s4), .half(pack_c));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
			v5_s5 <= 1'b0;
		end else begin
			if (cfg_we) begin
				enable_q <= cfg_wdata;
			end
			if (adv) begin
				v1_s1 <= in_ch.valid;
				v2_s2 <= v1_s1;
				v3_s3 <= v2_s2;
				v4_s4 <= v3_s3;
				v5_s5 <= v4_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			half_s1 <= in_ch.half_in;
			en_s1 <= enable_q;
			p_s2 <= add_c;
			p_s3 <= lzc_c;
			p_s4 <= rnd_c;
			half_s5 <= pack_c;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/fpo_check.sv =====
// fpo_check: port-level assertions for fp16_one_plus_gamma
// bound to the top level; depends on fp16_one_plus_gamma
`default_nettype none
module fpo_check (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [15:0] half_out
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(half_out))
		else $error("result changed while stalled");

	a_ready_flow: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input blocked while output drains");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready ##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready
		|=> out_valid)
		else $error("item not delivered after five cycles");
endmodule

bind fp16_one_plus_gamma fpo_check u_fpo_check (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_ch.valid),
	.in_ready(in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.half_out(out_ch.half_out)
);
`default_nettype wire
